@@ hw/rtl/ps2hcs_pkg.sv @@
// Types and constants shared by the PS/2 host command sequencer.
`timescale 1ns / 1ps
`default_nettype none
package ps2hcs_pkg;

   localparam logic [7:0]  RSP_ACK       = 8'hFA;
   localparam logic [15:0] TIMEOUT_RESET = 16'd1000;

   typedef enum logic [1:0] {
      OP_ENQUEUE = 2'd0,
      OP_POLL    = 2'd1,
      OP_RX      = 2'd2,
      OP_TICK    = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      PH_NOT_SENT = 2'd0,
      PH_SENDING  = 2'd1,
      PH_WAIT_ACK = 2'd2,
      PH_WAIT_RSP = 2'd3
   } phase_type;

   typedef struct packed {
      logic       port;
      logic [7:0] byte0;
      logic [7:0] byte1;
      logic [1:0] len;
      logic [7:0] remain;
      logic       idx;
      phase_type  phase;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef struct packed {
      logic [1:0] op;
      logic       port_sel;
      logic [7:0] cmd_byte;
      logic [7:0] arg_byte;
      logic [1:0] byte_count;
      logic [7:0] response_count;
      logic [7:0] rx_byte;
   } req_type;

   typedef struct packed {
      logic       accepted;
      logic       tx_valid;
      logic       tx_port;
      logic [7:0] tx_data;
      logic       timed_out;
      logic       timeout_port;
      logic [7:0] timeout_cmd;
      logic [7:0] timeout_arg;
      logic [1:0] timeout_len;
      logic       consumed;
      logic [2:0] queue_count;
   } rsp_type;

endpackage
`default_nettype wire

@@ hw/rtl/ps2hcs_ram.sv @@
// Generic single-port-write, single-port-read RAM with a registered read.
`timescale 1ns / 1ps
`default_nettype none
module ps2hcs_ram #(
   parameter int WIDTH = 30,
   parameter int DEPTH = 8
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule
`default_nettype wire

@@ hw/rtl/ps2_host_command_sequencer.sv @@
// PS/2 host command sequencer: command queue with acknowledge, resend and timeout.
// The request is registered and the head entry read from the command RAM on
// acceptance; the entry is modified and written back in the execute state, which
// waits while an earlier response is not taken; a new request waits for it to end.
// A pending response sits in an output register while the next request is read.
// Reset clears pointers, count and the ms counter and sets timeout_ms to 1000;
// the command RAM is not cleared.
`timescale 1ns / 1ps
`default_nettype none
module ps2_host_command_sequencer #(
   parameter int QUEUE_DEPTH = 8
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire ps2hcs_pkg::req_type  req_data,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output ps2hcs_pkg::rsp_type       rsp_data,
   input  wire logic                 csr_psel,
   input  wire logic                 csr_penable,
   input  wire logic                 csr_pwrite,
   input  wire logic [2:0]           csr_paddr,
   input  wire logic [31:0]          csr_pwdata,
   output logic      [31:0]          csr_prdata,
   output logic                      csr_pready
);
   import ps2hcs_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [PTR_W-1:0] FULL_CNT  = PTR_W'(QUEUE_DEPTH - 1);

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } state_type;

   state_type        state_ff, state_in;
   logic [PTR_W-1:0] head_ff, head_in;
   logic [PTR_W-1:0] tail_ff, tail_in;
   logic [PTR_W-1:0] count_ff, count_in;
   logic [15:0]      since_ff, since_in;
   logic [15:0]      timeout_ff;
   req_type          req_ff;
   rsp_type          rsp_ff, rsp_in;
   logic             rsp_valid_ff, rsp_valid_in;

   logic             ram_wr_en;
   logic [PTR_W-1:0] ram_wr_addr;
   entry_type        ram_wr_data;
   logic [ENTRY_W-1:0] ram_rd_data;
   entry_type        ent;
   logic             req_fire;
   logic             do_exec;
   logic             cfg_write;
   logic [15:0]      since_sat;

   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
      return (p == LAST_PTR) ? '0 : p + PTR_W'(1);
   endfunction

   assign req_ready  = (state_ff == ST_IDLE);
   assign req_fire   = req_valid && req_ready;
   assign do_exec    = (state_ff == ST_EXEC) && (!rsp_valid_ff || rsp_ready);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_ff;
   assign ent        = entry_type'(ram_rd_data);
   assign since_sat  = (since_ff == 16'hFFFF) ? since_ff : since_ff + 16'd1;

   assign cfg_write   = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready  = 1'b1;
   assign csr_prdata  = (csr_paddr[2] == 1'b0) ? {16'h0000, timeout_ff} : 32'h0000_0000;

   ps2hcs_ram #(
      .WIDTH(ENTRY_W),
      .DEPTH(QUEUE_DEPTH)
   ) u_cmd_ram (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(ram_wr_addr),
      .wr_data(ram_wr_data),
      .rd_en  (req_fire),
      .rd_addr(head_ff),
      .rd_data(ram_rd_data)
   );

   always_comb begin
      logic       drop;
      logic       check_to;
      logic [15:0] since_chk;
      drop         = 1'b0;
      check_to     = 1'b0;
      since_chk    = since_ff;
      state_in     = state_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      count_in     = count_ff;
      since_in     = since_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = head_ff;
      ram_wr_data  = ent;

      if (req_fire) begin
         state_in = ST_EXEC;
      end

      if (do_exec) begin
         state_in     = ST_IDLE;
         rsp_valid_in = 1'b1;
         rsp_in       = '0;
         case (op_type'(req_ff.op))
            OP_ENQUEUE: begin
               if (count_ff != FULL_CNT) begin
                  ram_wr_en         = 1'b1;
                  ram_wr_addr       = tail_ff;
                  ram_wr_data.port  = req_ff.port_sel;
                  ram_wr_data.len   = req_ff.byte_count[1] ? 2'd2 : 2'd1;
                  ram_wr_data.byte0 = req_ff.cmd_byte;
                  ram_wr_data.byte1 = req_ff.byte_count[1] ? req_ff.arg_byte : 8'h00;
                  ram_wr_data.remain = req_ff.response_count;
                  ram_wr_data.idx   = 1'b0;
                  ram_wr_data.phase = PH_NOT_SENT;
                  tail_in           = ptr_next(tail_ff);
                  count_in          = count_ff + PTR_W'(1);
                  rsp_in.accepted   = 1'b1;
               end
            end
            OP_POLL: begin
               if (count_ff != '0) begin
                  if (ent.phase[1]) begin
                     check_to = 1'b1;
                  end else begin
                     ram_wr_en         = 1'b1;
                     ram_wr_data.phase = PH_WAIT_ACK;
                     since_in          = 16'd0;
                     rsp_in.tx_valid   = 1'b1;
                     rsp_in.tx_port    = ent.port;
                     rsp_in.tx_data    = ent.idx ? ent.byte1 : ent.byte0;
                  end
               end
            end
            OP_RX: begin
               if (count_ff != '0 && ent.port == req_ff.port_sel) begin
                  if (ent.phase == PH_WAIT_RSP) begin
                     if (ent.remain <= 8'd1) begin
                        drop = 1'b1;
                     end else begin
                        ram_wr_en          = 1'b1;
                        ram_wr_data.remain = ent.remain - 8'd1;
                     end
                  end else if (ent.phase == PH_WAIT_ACK) begin
                     rsp_in.consumed = 1'b1;
                     if (req_ff.rx_byte == RSP_ACK) begin
                        if (!ent.idx && ent.len == 2'd2) begin
                           ram_wr_en         = 1'b1;
                           ram_wr_data.idx   = 1'b1;
                           ram_wr_data.phase = PH_SENDING;
                        end else if (ent.remain != 8'd0) begin
                           ram_wr_en         = 1'b1;
                           ram_wr_data.phase = PH_WAIT_RSP;
                        end else begin
                           drop = 1'b1;
                        end
                     end else begin
                        ram_wr_en         = 1'b1;
                        ram_wr_data.phase = PH_SENDING;
                     end
                  end
               end
            end
            OP_TICK: begin
               since_in  = since_sat;
               since_chk = since_sat;
               check_to  = 1'b1;
            end
            default: begin
            end
         endcase

         if (check_to && count_ff != '0 && ent.phase[1] && since_chk >= timeout_ff) begin
            rsp_in.timed_out    = 1'b1;
            rsp_in.timeout_port = ent.port;
            rsp_in.timeout_cmd  = ent.byte0;
            rsp_in.timeout_arg  = ent.byte1;
            rsp_in.timeout_len  = ent.len;
            drop                = 1'b1;
         end

         if (drop) begin
            head_in  = ptr_next(head_ff);
            count_in = count_ff - PTR_W'(1);
         end
         rsp_in.queue_count = 3'(count_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         since_ff     <= 16'd0;
         timeout_ff   <= TIMEOUT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         since_ff     <= since_in;
         rsp_valid_ff <= rsp_valid_in;
         if (cfg_write && csr_paddr[2] == 1'b0) begin
            timeout_ff <= csr_pwdata[15:0];
         end
      end
      if (req_fire) begin
         req_ff <= req_data;
      end
      if (do_exec) begin
         rsp_ff <= rsp_in;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_CNT)
      else $error("queue count exceeds capacity");

   a_rsp_from_exec: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_EXEC))
      else $error("response raised without an execute cycle");

   a_count_change: assert property (@(posedge clock) disable iff (reset)
      (count_ff != $past(count_ff)) |-> $past(do_exec))
      else $error("queue count changed outside an execute cycle");

   a_write_in_exec: assert property (@(posedge clock) disable iff (reset)
      ram_wr_en |-> do_exec)
      else $error("command RAM written outside an execute cycle");

endmodule
`default_nettype wire

@@ tb/tb_top.sv @@
// Self-checking testbench for the PS/2 host command sequencer with a scoreboard class.
`timescale 1ns / 1ps
module tb_top;
   import ps2hcs_pkg::*;

   localparam int          QUEUE_DEPTH  = 8;
   localparam logic [2:0]  TIMEOUT_ADDR = 3'd0;
   localparam logic [7:0]  RESEND_BYTE  = 8'hFE;
   localparam int          PHASE_ITEMS  = 215;

   class ps2_scoreboard;
      entry_type   cmd_q[QUEUE_DEPTH];
      int          head_idx;
      int          tail_idx;
      int          held;
      int          ms_since_send;
      logic [15:0] timeout_ms;
      rsp_type     pending_rsp[$];
      int          errors;

      function new();
         foreach (cmd_q[i]) cmd_q[i] = '0;
         head_idx = 0;
         tail_idx = 0;
         held = 0;
         ms_since_send = 0;
         timeout_ms = TIMEOUT_RESET;
         errors = 0;
      endfunction

      function void set_timeout(logic [15:0] value);
         timeout_ms = value;
      endfunction

      function int pending();
         return pending_rsp.size();
      endfunction

      function bit head_waiting();
         if (held == 0) return 1'b0;
         return cmd_q[head_idx].phase == PH_WAIT_ACK || cmd_q[head_idx].phase == PH_WAIT_RSP;
      endfunction

      function void drop_head();
         if (held == 0) return;
         head_idx = (head_idx + 1) % QUEUE_DEPTH;
         held--;
      endfunction

      function void try_timeout(inout rsp_type o);
         if (!head_waiting() || ms_since_send < timeout_ms) return;
         o.timed_out    = 1'b1;
         o.timeout_port = cmd_q[head_idx].port;
         o.timeout_cmd  = cmd_q[head_idx].byte0;
         o.timeout_arg  = cmd_q[head_idx].byte1;
         o.timeout_len  = cmd_q[head_idx].len;
         drop_head();
      endfunction

      function void note_request(req_type r);
         rsp_type   o;
         entry_type e;
         int        nxt;
         bit        drop_it;
         o = '0;
         drop_it = 1'b0;
         case (op_type'(r.op))
            OP_ENQUEUE: begin
               if (held + 1 < QUEUE_DEPTH) begin
                  e = '0;
                  e.port   = r.port_sel;
                  e.len    = (r.byte_count >= 2'd2) ? 2'd2 : 2'd1;
                  e.byte0  = r.cmd_byte;
                  e.byte1  = (e.len == 2'd2) ? r.arg_byte : 8'h00;
                  e.remain = r.response_count;
                  e.idx    = 1'b0;
                  e.phase  = PH_NOT_SENT;
                  cmd_q[tail_idx] = e;
                  tail_idx = (tail_idx + 1) % QUEUE_DEPTH;
                  held++;
                  o.accepted = 1'b1;
               end
            end
            OP_POLL: begin
               if (held != 0) begin
                  if (head_waiting()) begin
                     try_timeout(o);
                  end else begin
                     cmd_q[head_idx].phase = PH_WAIT_ACK;
                     ms_since_send = 0;
                     o.tx_valid = 1'b1;
                     o.tx_port  = cmd_q[head_idx].port;
                     o.tx_data  = cmd_q[head_idx].idx ? cmd_q[head_idx].byte1
                                                      : cmd_q[head_idx].byte0;
                  end
               end
            end
            OP_RX: begin
               if (held != 0 && cmd_q[head_idx].port == r.port_sel) begin
                  e = cmd_q[head_idx];
                  if (e.phase == PH_WAIT_RSP) begin
                     if (e.remain <= 8'd1) begin
                        e.remain = 8'd0;
                        drop_it = 1'b1;
                     end else begin
                        e.remain = e.remain - 8'd1;
                     end
                  end else if (e.phase == PH_WAIT_ACK) begin
                     o.consumed = 1'b1;
                     if (r.rx_byte == RSP_ACK) begin
                        nxt = int'(e.idx) + 1;
                        if (nxt < e.len) begin
                           e.idx = 1'b1;
                           e.phase = PH_SENDING;
                        end else if (e.remain > 8'd0) begin
                           e.phase = PH_WAIT_RSP;
                        end else begin
                           drop_it = 1'b1;
                        end
                     end else begin
                        e.phase = PH_SENDING;
                     end
                  end
                  cmd_q[head_idx] = e;
                  if (drop_it) drop_head();
               end
            end
            OP_TICK: begin
               if (ms_since_send < 65535) ms_since_send++;
               try_timeout(o);
            end
         endcase
         o.queue_count = held[2:0];
         pending_rsp = {pending_rsp, o};
      endfunction

      function void compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
         if (act_v !== exp_v) begin
            $error("%s: expected %0h actual %0h", name, exp_v, act_v);
            errors++;
         end
      endfunction

      function void check_response(rsp_type act);
         rsp_type exp_r;
         if (pending_rsp.size() == 0) begin
            $error("response arrived with no request outstanding: %0h", act);
            errors++;
            return;
         end
         exp_r = pending_rsp.pop_front();
         compare_field("accepted", exp_r.accepted, act.accepted);
         compare_field("tx_valid", exp_r.tx_valid, act.tx_valid);
         compare_field("tx_port", exp_r.tx_port, act.tx_port);
         compare_field("tx_data", exp_r.tx_data, act.tx_data);
         compare_field("timed_out", exp_r.timed_out, act.timed_out);
         compare_field("timeout_port", exp_r.timeout_port, act.timeout_port);
         compare_field("timeout_cmd", exp_r.timeout_cmd, act.timeout_cmd);
         compare_field("timeout_arg", exp_r.timeout_arg, act.timeout_arg);
         compare_field("timeout_len", exp_r.timeout_len, act.timeout_len);
         compare_field("consumed", exp_r.consumed, act.consumed);
         compare_field("queue_count", exp_r.queue_count, act.queue_count);
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   rsp_type     rsp_data;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   ps2_scoreboard sb = new();
   bit          calm = 1'b0;
   int          rsp_stall = 0;

   ps2_host_command_sequencer #(.QUEUE_DEPTH(QUEUE_DEPTH)) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) sb.check_response(rsp_data);
      if (rsp_stall > 1) begin
         rsp_stall <= rsp_stall - 1;
      end else if (rsp_stall == 1) begin
         rsp_stall <= 0;
         rsp_ready <= 1'b1;
      end else if (!calm && $urandom_range(0, 11) == 0) begin
         rsp_stall <= $urandom_range(1, 14);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   function automatic req_type make_req(op_type op, logic port, logic [7:0] cmd,
                                        logic [7:0] arg, logic [1:0] count,
                                        logic [7:0] rsp_count, logic [7:0] rx);
      req_type r;
      r.op             = op;
      r.port_sel       = port;
      r.cmd_byte       = cmd;
      r.arg_byte       = arg;
      r.byte_count     = count;
      r.response_count = rsp_count;
      r.rx_byte        = rx;
      return r;
   endfunction

   function automatic req_type random_request(int enq_pct);
      req_type    r;
      logic [63:0] raw;
      int         pick;
      int         sel;
      entry_type  h;
      raw = {$urandom, $urandom};
      r = raw[$bits(req_type)-1:0];
      pick = $urandom_range(0, 99);
      if (pick < 8) return r;
      h = sb.cmd_q[sb.head_idx];
      sel = $urandom_range(0, 99);
      if (sb.held == 0) begin
         r.op = (sel < 70) ? OP_ENQUEUE : ((sel < 85) ? OP_POLL : OP_TICK);
      end else if (sel < enq_pct) begin
         r.op = OP_ENQUEUE;
      end else if (sel < enq_pct + (100 - enq_pct) * 3 / 10) begin
         r.op = OP_POLL;
      end else if (sel < enq_pct + (100 - enq_pct) * 8 / 10) begin
         r.op = OP_RX;
      end else begin
         r.op = OP_TICK;
      end
      r.byte_count = $urandom_range(1, 2);
      sel = $urandom_range(0, 9);
      r.response_count = (sel < 5) ? 8'd0 : ((sel < 9) ? 8'($urandom_range(1, 3))
                                                        : 8'($urandom_range(0, 255)));
      if (sb.held != 0) begin
         r.port_sel = ($urandom_range(0, 99) < 85) ? h.port : ~h.port;
         sel = $urandom_range(0, 99);
         if (h.phase == PH_WAIT_ACK)
            r.rx_byte = (sel < 65) ? RSP_ACK : ((sel < 80) ? RESEND_BYTE : r.rx_byte);
         else if (sel < 50)
            r.rx_byte = RSP_ACK;
      end
      return r;
   endfunction

   task automatic send_request(req_type r);
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (!req_ready);
      sb.note_request(r);
   endtask

   task automatic issue(req_type r);
      if (!calm && $urandom_range(0, 9) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
      send_request(r);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_update(logic [15:0] value);
      wait_idle();
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= TIMEOUT_ADDR;
      csr_pwdata <= {16'h0000, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      sb.set_timeout(value);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
      csr_psel <= 1'b1;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== {16'h0000, value}) begin
         $error("timeout_ms readback: expected %0h actual %0h", value, csr_prdata);
         sb.errors++;
      end
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   initial begin
      logic [15:0] phase_timeout[6];
      int          k;
      int          n;
      phase_timeout = '{16'd1, 16'd4, 16'd12, 16'd40, 16'd1000, 16'd65535};
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      issue(make_req(OP_POLL, 1'b0, 8'h00, 8'h00, 2'd1, 8'd0, 8'h00));
      issue(make_req(OP_RX, 1'b0, 8'h00, 8'h00, 2'd1, 8'd0, RSP_ACK));
      issue(make_req(OP_TICK, 1'b0, 8'h00, 8'h00, 2'd1, 8'd0, 8'h00));
      issue(make_req(OP_ENQUEUE, 1'b0, 8'hFF, 8'hFF, 2'd1, 8'd0, 8'h00));
      issue(make_req(OP_RX, 1'b0, 8'h00, 8'h00, 2'd1, 8'd0, RSP_ACK));
      issue(make_req(OP_POLL, 1'b0, 8'h00, 8'h00, 2'd1, 8'd0, 8'h00));
      issue(make_req(OP_RX, 1'b1, 8'h00, 8'h00, 2'd1, 8'd0, RSP_ACK));
      issue(make_req(OP_RX, 1'b0, 8'h00, 8'h00, 2'd1, 8'd0, RESEND_BYTE));
      issue(make_req(OP_POLL, 1'b0, 8'h00, 8'h00, 2'd1, 8'd0, 8'h00));
      issue(make_req(OP_RX, 1'b0, 8'h00, 8'h00, 2'd1, 8'd0, 8'h00));
      issue(make_req(OP_POLL, 1'b0, 8'h00, 8'h00, 2'd1, 8'd0, 8'h00));
      issue(make_req(OP_RX, 1'b0, 8'h00, 8'h00, 2'd1, 8'd0, RSP_ACK));
      issue(make_req(OP_ENQUEUE, 1'b1, 8'h00, 8'hFF, 2'd2, 8'd2, 8'h00));
      issue(make_req(OP_ENQUEUE, 1'b0, 8'h55, 8'hAA, 2'd0, 8'd255, 8'h00));
      issue(make_req(OP_ENQUEUE, 1'b1, 8'hA5, 8'h5A, 2'd3, 8'd1, 8'h00));
      issue(make_req(OP_POLL, 1'b0, 8'h00, 8'h00, 2'd1, 8'd0, 8'h00));
      issue(make_req(OP_POLL, 1'b0, 8'h00, 8'h00, 2'd1, 8'd0, 8'h00));
      issue(make_req(OP_RX, 1'b1, 8'h00, 8'h00, 2'd1, 8'd0, RSP_ACK));
      issue(make_req(OP_RX, 1'b1, 8'h00, 8'h00, 2'd1, 8'd0, RSP_ACK));
      issue(make_req(OP_POLL, 1'b0, 8'h00, 8'h00, 2'd1, 8'd0, 8'h00));
      issue(make_req(OP_RX, 1'b1, 8'h00, 8'h00, 2'd1, 8'd0, RSP_ACK));
      issue(make_req(OP_RX, 1'b1, 8'h00, 8'h00, 2'd1, 8'd0, 8'h12));
      issue(make_req(OP_RX, 1'b1, 8'h00, 8'h00, 2'd1, 8'd0, RSP_ACK));
      repeat (6) issue(make_req(OP_ENQUEUE, 1'($urandom), 8'($urandom), 8'($urandom),
                                2'($urandom_range(1, 2)), 8'($urandom_range(0, 2)), 8'h00));

      csr_update(16'd0);
      issue(make_req(OP_POLL, 1'b0, 8'h00, 8'h00, 2'd1, 8'd0, 8'h00));
      issue(make_req(OP_TICK, 1'b0, 8'h00, 8'h00, 2'd1, 8'd0, 8'h00));
      issue(make_req(OP_POLL, 1'b0, 8'h00, 8'h00, 2'd1, 8'd0, 8'h00));
      issue(make_req(OP_POLL, 1'b0, 8'h00, 8'h00, 2'd1, 8'd0, 8'h00));

      csr_update(16'd50);
      issue(make_req(OP_POLL, 1'b0, 8'h00, 8'h00, 2'd1, 8'd0, 8'h00));
      while (sb.head_waiting())
         issue(make_req(OP_TICK, 1'b0, 8'h00, 8'h00, 2'd1, 8'd0, 8'h00));

      for (k = 0; k < 6; k++) begin
         csr_update(phase_timeout[k]);
         if (k == 5) calm = 1'b1;
         for (n = 0; n < PHASE_ITEMS; n++) begin
            if (k == 2 && n == PHASE_ITEMS / 2) wait_idle();
            issue(random_request((k % 2 == 0) ? 15 : 45));
         end
      end

      wait_idle();
      repeat (6) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("tb_top: clean");
      end else begin
         $display("tb_top: errors");
      end
      $finish;
   end

   initial begin
      #30000000;
      $display("tb_top: errors");
      $finish;
   end
endmodule

@@ filelist.f @@
hw/rtl/ps2hcs_pkg.sv
hw/rtl/ps2hcs_ram.sv
hw/rtl/ps2_host_command_sequencer.sv
tb/tb_top.sv
